// ===== sv/pcr_pkg.sv =====
// pcr_pkg: shared widths, controller states and the command/status bundles
// for the prime range counter; no dependencies
package pcr_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int COUNT_WIDTH   = VALUE_WIDTH + 1;
    // divisor squared can step just past the largest candidate
    localparam int SQ_WIDTH      = VALUE_WIDTH + 2;
    localparam int BIT_IDX_WIDTH = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TEST,
        ST_MOD_WAIT,
        ST_ADVANCE,
        ST_FINISH
    } pcr_state_t;

    typedef struct packed {
        logic load;
        logic init_div;
        logic step_div;
        logic mod_start;
        logic count_inc;
        logic cand_inc;
        logic out_load;
    } pcr_cmd_t;

    typedef struct packed {
        logic range_empty;
        logic cand_small;
        logic sq_gt_cand;
        logic mod_done;
        logic rem_zero;
        logic cand_last;
        logic out_free;
    } pcr_status_t;

endpackage

// ===== sv/prime_count_in_range.sv =====
// prime_count_in_range: top level, controller plus datapath
// depends on pcr_pkg, pcr_ctrl, pcr_datapath
//
// Counts the primes p with range_low <= p <= range_high by trial division;
// an empty range gives 0, and 0 and 1 are not prime. One query is worked on
// at a time and its latency depends on the data, set by the number of
// candidates and trial divisors tried; each trial division uses the
// bit-serial remainder unit that takes one dividend bit per cycle. A finished
// count sits in an output register, so the next query is accepted while the
// previous count waits to be taken.
module prime_count_in_range
    import pcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_range_low,
    input  logic [VALUE_WIDTH-1:0] s_range_high,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_WIDTH-1:0] m_prime_count
);

    pcr_cmd_t    cmd;
    pcr_status_t stat;

    pcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pcr_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_count (m_prime_count)
    );

endmodule

// ===== sv/pcr_mod_unit.sv =====
// pcr_mod_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on pcr_pkg
module pcr_mod_unit
    import pcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic                   rem_zero
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [BIT_IDX_WIDTH-1:0] idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0]   shift_reg, shift_next;
    logic [VALUE_WIDTH-1:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH:0]     trial;
    logic [VALUE_WIDTH:0]     diff;

    assign trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next  = 1'b1;
            idx_next   = BIT_IDX_WIDTH'(VALUE_WIDTH - 1);
            shift_next = dividend;
            rem_next   = '0;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            // remainder stays below the divisor, so the low bits hold it
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[VALUE_WIDTH-1:0];
            end else begin
                rem_next = trial[VALUE_WIDTH-1:0];
            end
            if (idx_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        idx_reg   <= idx_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg && !done_reg)
        else $error("remainder unit started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("remainder done without a running division");

endmodule

// ===== sv/pcr_datapath.sv =====
// pcr_datapath: candidate, bound, trial divisor and count registers, the
// remainder unit and the result register; depends on pcr_pkg, pcr_mod_unit
module pcr_datapath
    import pcr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [VALUE_WIDTH-1:0] s_range_low,
    input  logic [VALUE_WIDTH-1:0] s_range_high,
    input  pcr_cmd_t               cmd,
    output pcr_status_t            stat,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_WIDTH-1:0] m_prime_count
);

    logic [VALUE_WIDTH-1:0] cand_reg;
    logic [VALUE_WIDTH-1:0] hi_reg;
    logic [VALUE_WIDTH-1:0] div_reg;
    logic [SQ_WIDTH-1:0]    sq_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   mod_done;
    logic                   rem_zero;

    pcr_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .done     (mod_done),
        .rem_zero (rem_zero)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cand_reg  <= s_range_low;
            hi_reg    <= s_range_high;
            count_reg <= '0;
        end else begin
            if (cmd.cand_inc) begin
                cand_reg <= cand_reg + 1'b1;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + 1'b1;
            end
        end
        if (cmd.init_div) begin
            div_reg <= VALUE_WIDTH'(2);
            sq_reg  <= SQ_WIDTH'(4);
        end else if (cmd.step_div) begin
            // (d+1)^2 = d^2 + 2d + 1
            div_reg <= div_reg + 1'b1;
            sq_reg  <= sq_reg + {1'b0, div_reg, 1'b1};
        end
        if (cmd.out_load) begin
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        stat.range_empty = (cand_reg > hi_reg);
        stat.cand_small  = (cand_reg < VALUE_WIDTH'(2));
        stat.sq_gt_cand  = (sq_reg > {2'b00, cand_reg});
        stat.mod_done    = mod_done;
        stat.rem_zero    = rem_zero;
        stat.cand_last   = (cand_reg == hi_reg);
        stat.out_free    = !out_valid_reg || m_ready;
    end

    assign m_valid       = out_valid_reg;
    assign m_prime_count = out_count_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc |-> !stat.cand_small && stat.sq_gt_cand)
        else $error("count raised for a candidate not proven prime");

endmodule

// ===== sv/pcr_ctrl.sv =====
// pcr_ctrl: sequencer over candidates and trial divisors
// depends on pcr_pkg
module pcr_ctrl
    import pcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pcr_status_t stat,
    output pcr_cmd_t    cmd
);

    pcr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    cmd.init_div = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = stat.range_empty ? ST_FINISH : ST_TEST;
            end
            ST_TEST: begin
                if (stat.cand_small) begin
                    state_next = ST_ADVANCE;
                end else if (stat.sq_gt_cand) begin
                    // no divisor up to the square root
                    cmd.count_inc = 1'b1;
                    state_next    = ST_ADVANCE;
                end else begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT: begin
                if (stat.mod_done) begin
                    if (stat.rem_zero) begin
                        state_next = ST_ADVANCE;
                    end else begin
                        cmd.step_div = 1'b1;
                        state_next   = ST_TEST;
                    end
                end
            end
            ST_ADVANCE: begin
                if (stat.cand_last) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.cand_inc = 1'b1;
                    cmd.init_div = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten before transaction");

    a_mod_start_needed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_start |-> !stat.sq_gt_cand && !stat.cand_small)
        else $error("trial division started past the square root");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.mod_done |-> state_reg == ST_MOD_WAIT)
        else $error("remainder result arrived outside the wait state");

endmodule
